// ===== design/itpm_pkg.sv =====
`default_nettype none

package itpm_pkg;

	localparam int NODE_COUNT_DEF = 4096;
	localparam int ADDR_BITS_DEF  = 32;

	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam int ASN_W    = 32;
	localparam int STATUS_W = 2;

	// stream widths: fields packed from bit 0, tdata padded to whole bytes
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} itpm_status_t;

	// classified item between front and walker
	typedef struct packed {
		logic              insert;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  lim;
		logic [ASN_W-1:0]  asn;
	} itpm_item_t;

	typedef struct packed {
		logic [ASN_W-1:0] asn;
		itpm_status_t     status;
	} itpm_result_t;

endpackage

`default_nettype wire

// ===== design/itpm_ram.sv =====
`default_nettype none

module itpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/itpm_front.sv =====
`default_nettype none

module itpm_front #(
	parameter int ADDR_BITS = itpm_pkg::ADDR_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [itpm_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [itpm_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                                q_valid,
	output itpm_pkg::itpm_item_t                q_item,
	input  wire logic                           q_pop
);

	localparam int QD = itpm_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(QD);
	localparam int CW = $clog2(QD + 1);
	localparam int AW = itpm_pkg::ADDR_W;
	localparam int LW = itpm_pkg::LEN_W;
	localparam int NW = itpm_pkg::ASN_W;

	itpm_pkg::itpm_item_t entry_q [QD];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	itpm_pkg::itpm_item_t cls;
	logic [LW-1:0] plen;
	logic push;

	// lookups may walk the full depth, inserts stop at the saturated prefix length
	always_comb begin
		plen       = s_axis_tdata[AW +: LW];
		cls.insert = s_axis_tuser[0];
		cls.addr   = s_axis_tdata[0 +: AW];
		cls.asn    = s_axis_tdata[AW + LW +: NW];
		if (!s_axis_tuser[0] || plen > LW'(ADDR_BITS)) begin
			cls.lim = LW'(ADDR_BITS);
		end else begin
			cls.lim = plen;
		end
	end

	assign s_axis_tready = count_q != CW'(QD);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = count_q != '0;
	assign q_item        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/itpm_walker.sv =====
`default_nettype none

module itpm_walker #(
	parameter int NODE_COUNT = itpm_pkg::NODE_COUNT_DEF,
	parameter int ADDR_BITS  = itpm_pkg::ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire itpm_pkg::itpm_item_t q_item,
	output logic                      q_pop,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output itpm_pkg::itpm_result_t    res
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int FW = NW + 1;
	localparam int SW = itpm_pkg::ASN_W;
	localparam int EW = SW + 2 * NW;
	localparam int LW = itpm_pkg::LEN_W;
	localparam int AW = itpm_pkg::ADDR_W;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_WALK,
		WK_RESULT
	} wk_state_t;

	wk_state_t state_q;
	itpm_pkg::itpm_item_t item_q;
	logic [AW-1:0] shift_q;
	logic [LW-1:0] depth_q;
	logic [NW-1:0] node_q;
	logic fresh_q;
	logic root_written_q;
	logic [SW-1:0] best_q;
	logic [FW-1:0] next_free_q;
	itpm_pkg::itpm_result_t res_q;

	logic [EW-1:0] rdata, ent, wdata;
	logic [NW-1:0] e_c0, e_c1, child, nf_idx, raddr;
	logic [SW-1:0] e_asn, best_nx;
	logic bit_w, at_end, pool_full;
	logic we, done, go_child, alloc;
	itpm_pkg::itpm_result_t res_nx;

	itpm_ram #(
		.WIDTH(EW),
		.DEPTH(NODE_COUNT)
	) u_nodes (
		.clk  (clk),
		.we   (we),
		.waddr(node_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// a freshly allocated node, or the root before its first write, reads as empty
	assign ent       = fresh_q ? '0 : rdata;
	assign e_c0      = ent[0 +: NW];
	assign e_c1      = ent[NW +: NW];
	assign e_asn     = ent[2 * NW +: SW];
	assign bit_w     = shift_q[ADDR_BITS-1];
	assign child     = bit_w ? e_c1 : e_c0;
	assign at_end    = depth_q == item_q.lim;
	assign pool_full = next_free_q == FW'(NODE_COUNT);
	assign nf_idx    = next_free_q[NW-1:0];
	assign best_nx   = (e_asn != '0) ? e_asn : best_q;
	assign q_pop     = state_q == WK_IDLE && q_valid;
	assign res_valid = state_q == WK_RESULT;
	assign res       = res_q;

	always_comb begin
		we       = 1'b0;
		wdata    = ent;
		raddr    = '0;
		done     = 1'b0;
		go_child = 1'b0;
		alloc    = 1'b0;
		res_nx   = '{asn: '0, status: itpm_pkg::ST_OK};
		if (state_q == WK_WALK) begin
			if (!item_q.insert) begin
				if (at_end || child == '0) begin
					done       = 1'b1;
					res_nx.asn = best_nx;
				end else begin
					go_child = 1'b1;
				end
			end else if (at_end) begin
				done = 1'b1;
				if (e_asn != '0) begin
					res_nx.status = itpm_pkg::ST_DUP;
				end else begin
					we    = 1'b1;
					wdata = {item_q.asn, e_c1, e_c0};
				end
			end else if (child != '0) begin
				go_child = 1'b1;
			end else if (pool_full) begin
				// last node taken so far stays in the trie, empty
				done          = 1'b1;
				res_nx.status = itpm_pkg::ST_FULL;
				we            = fresh_q;
				wdata         = '0;
			end else begin
				alloc = 1'b1;
				we    = 1'b1;
				wdata = bit_w ? {e_asn, nf_idx, e_c0} : {e_asn, e_c1, nf_idx};
			end
			if (go_child) begin
				raddr = child;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= WK_IDLE;
			item_q         <= '0;
			shift_q        <= '0;
			depth_q        <= '0;
			node_q         <= '0;
			fresh_q        <= 1'b0;
			root_written_q <= 1'b0;
			best_q         <= '0;
			next_free_q    <= FW'(1);
			res_q          <= '{asn: '0, status: itpm_pkg::ST_OK};
		end else begin
			unique case (state_q)
				WK_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						shift_q <= q_item.addr;
						depth_q <= '0;
						node_q  <= '0;
						fresh_q <= !root_written_q;
						best_q  <= '0;
						state_q <= WK_WALK;
					end
				end
				WK_WALK: begin
					best_q <= best_nx;
					if (we && node_q == '0) begin
						root_written_q <= 1'b1;
					end
					if (done) begin
						res_q   <= res_nx;
						state_q <= WK_RESULT;
					end else if (go_child) begin
						node_q  <= child;
						depth_q <= depth_q + LW'(1);
						shift_q <= shift_q << 1;
					end else if (alloc) begin
						node_q      <= nf_idx;
						next_free_q <= next_free_q + FW'(1);
						depth_q     <= depth_q + LW'(1);
						shift_q     <= shift_q << 1;
						fresh_q     <= 1'b1;
					end
				end
				WK_RESULT: begin
					if (res_ready) begin
						state_q <= WK_IDLE;
					end
				end
				default: begin
					state_q <= WK_IDLE;
				end
			endcase
		end
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FW'(NODE_COUNT) && next_free_q != '0)
		else $error("next free node out of range");

	a_fresh_no_child: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_WALK && fresh_q) |-> !go_child)
		else $error("walk followed a child out of an empty node");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WK_WALK |-> depth_q <= item_q.lim)
		else $error("walk went past its depth limit");

	a_alloc_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> (fresh_q && state_q == WK_WALK && node_q == $past(nf_idx)))
		else $error("allocated node not taken as current");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WK_RESULT && item_q.insert) |-> res_q.asn == '0)
		else $error("insert returned a nonzero asn");

endmodule

`default_nettype wire

// ===== design/ipv4_trie_prefix_match.sv =====
// channel  | direction | tdata (low bit up)                            | tuser       | tlast
// s_axis   | in        | address[31:0] mask_len[5:0] asn_value[31:0]   | action[0]   | -
// m_axis   | out       | found_asn[31:0]                               | status[1:0] | -
//
// in the walker an item is dispatched, then reads one node for each of the depth + 1
// levels on the node memory's single read port, then presents its result
// a lookup walks at most ADDR_BITS levels deep, an insert to its saturated mask length,
// less deep when the node pool runs out
// reset: no clearing pass, the root reads as empty until first written, next free node is 1
// a two-item queue keeps accepting, until full, while the walker works or its result waits to be taken
`default_nettype none

module ipv4_trie_prefix_match #(
	parameter int NODE_COUNT = itpm_pkg::NODE_COUNT_DEF,
	parameter int ADDR_BITS  = itpm_pkg::ADDR_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// address[31:0], mask_len[37:32], asn_value[69:38], zero pad
	input  wire logic [itpm_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// action[0]
	input  wire logic [itpm_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// found_asn[31:0]
	output logic      [itpm_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic      [itpm_pkg::M_TUSER_W-1:0] m_axis_tuser
);

	logic q_valid, q_pop;
	itpm_pkg::itpm_item_t q_item;
	itpm_pkg::itpm_result_t res;

	itpm_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	itpm_walker #(
		.NODE_COUNT(NODE_COUNT),
		.ADDR_BITS (ADDR_BITS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = res.asn;
	assign m_axis_tuser = res.status;

endmodule

`default_nettype wire
